@@ sv/smv_pkg.sv @@
// Package for the sample voice mixer: request, result and scale control types, operation
// codes, configuration register indexes and reset values, and the output saturation limits.
// No dependencies.
package smv_pkg;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [15:0]        address;
        logic signed [15:0] sample_value;
    } request_t;

    typedef struct packed {
        logic signed [15:0] mixed_sample;
        logic [3:0]         active_voices;
    } result_t;

    typedef struct packed {
        logic mul_en;
        logic out_en;
    } scale_ctrl_t;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_TRIGGER = 2'd1;
    localparam logic [1:0] OP_FRAME   = 2'd2;

    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_STEP   = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;

    localparam int CFG_W = 22;

    localparam logic [16:0] LENGTH_RESET = 17'd0;
    localparam logic [21:0] STEP_RESET   = 22'd65536;
    localparam logic [8:0]  GAIN_RESET   = 9'd256;
    localparam logic [8:0]  GAIN_UNITY   = 9'd256;

    localparam int SAT_MAX = 32767;
    localparam int SAT_MIN = -32768;

endpackage

@@ sv/sample_voice_mixer_core.sv @@
// Top level of the sample voice mixer: sample memory, voice position memory,
// voice sequencer and interpolation datapath.
// Depends on smv_pkg and smv_out_scale.
//
//  Channel   Signals                          Direction  Handshake
//  request   start, busy, request             in         start && !busy
//  result    done, result                     out        done, one cycle, no stall
//  config    cfg_we, cfg_index, cfg_data      in         cfg_we, no wait
//
// Write and trigger requests leave busy low.
// A frame request walks the voices in order; the single-port walk takes a playing voice
// through the position read, the end check, two sample reads, the multiply and the
// accumulate, stops a voice that reaches its end after the check and skips an idle voice.
// The scale and output states follow the walk, and the result strobe follows the frame.
// Reset clears the voice active bits and returns the configuration registers to their
// reset values; the sample memory holds whatever was written and needs no clearing pass.
module sample_voice_mixer_core #(
    parameter int VOICE_COUNT  = 8,
    parameter int SAMPLE_DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  smv_pkg::request_t        request,
    output logic                     done,
    output smv_pkg::result_t         result,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [smv_pkg::CFG_W-1:0] cfg_data
);
    import smv_pkg::*;

    // The sample depth must be a power of two so that index wrapping is a mask; the block does not check it.
    localparam int AW    = $clog2(SAMPLE_DEPTH);
    localparam int VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CNT_W = $clog2(VOICE_COUNT + 1);
    localparam int SUM_W = 17 + $clog2(VOICE_COUNT);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_POS   = 3'd1;
    localparam logic [2:0] ST_CHK   = 3'd2;
    localparam logic [2:0] ST_RD1   = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_SCALE = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]               state_reg, state_next;
    logic [VW-1:0]            voice_reg, voice_next;
    logic [VOICE_COUNT-1:0]   active_reg, active_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [16:0]              length_reg;
    logic [21:0]              step_reg;
    logic [8:0]               gain_reg;

    logic [15:0]              smp_mem [SAMPLE_DEPTH];
    logic [15:0]              smp_rd_reg;
    logic [AW-1:0]            smp_raddr;
    logic                     smp_we;
    logic [39:0]              pos_mem [VOICE_COUNT];
    logic [39:0]              pos_rd_reg;
    logic                     pos_we;
    logic [VW-1:0]            pos_waddr;
    logic [39:0]              pos_wdata;

    logic signed [15:0]       p0_reg;
    logic signed [33:0]       prod_reg;
    logic signed [16:0]       diff;
    logic signed [34:0]       interp_t;
    logic signed [18:0]       interp_s;
    logic signed [15:0]       interp_v;
    logic                     at_end;
    logic                     last_voice;
    logic                     accept;
    logic [VW-1:0]            free_slot;
    scale_ctrl_t              scale_ctrl;

    function automatic logic p1_sign(input logic [15:0] w);
        return w[15];
    endfunction

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign last_voice = (voice_reg == VW'(VOICE_COUNT - 1));
    assign at_end     = ({1'b0, pos_rd_reg} + 41'd65536) >= {8'd0, length_reg, 16'd0};
    assign smp_we     = accept && (request.opcode == OP_WRITE);

    always_comb
    begin
        free_slot = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_slot = VW'(i);
            end
        end
    end

    assign diff     = $signed({p1_sign(smp_rd_reg), smp_rd_reg}) - $signed({p0_reg[15], p0_reg});
    assign interp_t = $signed({{3{p0_reg[15]}}, p0_reg, 16'd0}) + $signed({prod_reg[33], prod_reg});
    assign interp_s = interp_t[34:16]
                    + 19'({1'b0, interp_t[34] && (interp_t[15:0] != 16'd0)});
    assign interp_v = interp_s[15:0];

    always_comb
    begin
        smp_raddr = pos_rd_reg[16 +: AW];
        if (state_reg == ST_RD1)
        begin
            smp_raddr = pos_rd_reg[16 +: AW] + AW'(1);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        voice_next  = voice_reg;
        active_next = active_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        pos_we      = 1'b0;
        pos_waddr   = voice_reg;
        pos_wdata   = pos_rd_reg + {18'd0, step_reg};
        scale_ctrl  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (request.opcode == OP_TRIGGER) && (length_reg != 17'd0))
                begin
                    pos_we                 = 1'b1;
                    pos_waddr              = free_slot;
                    pos_wdata              = '0;
                    active_next[free_slot] = 1'b1;
                end
                else if (accept && (request.opcode == OP_FRAME))
                begin
                    voice_next = '0;
                    count_next = '0;
                    sum_next   = '0;
                    state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                if (active_reg[voice_reg])
                begin
                    state_next = ST_CHK;
                end
                else if (last_voice)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    voice_next = voice_reg + VW'(1);
                end
            end
            ST_CHK:
            begin
                if (at_end)
                begin
                    active_next[voice_reg] = 1'b0;
                    if (last_voice)
                    begin
                        state_next = ST_SCALE;
                    end
                    else
                    begin
                        voice_next = voice_reg + VW'(1);
                        state_next = ST_POS;
                    end
                end
                else
                begin
                    state_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                pos_we     = 1'b1;
                sum_next   = sum_reg + {{(SUM_W - 16){interp_v[15]}}, interp_v};
                count_next = count_reg + CNT_W'(1);
                if (last_voice)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    voice_next = voice_reg + VW'(1);
                    state_next = ST_POS;
                end
            end
            ST_SCALE:
            begin
                scale_ctrl.mul_en = 1'b1;
                state_next        = ST_OUT;
            end
            ST_OUT:
            begin
                scale_ctrl.out_en = 1'b1;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (smp_we)
        begin
            smp_mem[AW'(request.address)] <= request.sample_value;
        end
        smp_rd_reg <= smp_mem[smp_raddr];
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rd_reg <= pos_mem[voice_reg];
        if (state_reg == ST_RD1)
        begin
            p0_reg <= smp_rd_reg;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= diff * $signed({1'b0, pos_rd_reg[15:0]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            voice_reg  <= '0;
            active_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            length_reg <= LENGTH_RESET;
            step_reg   <= STEP_RESET;
            gain_reg   <= GAIN_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            voice_reg  <= voice_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LENGTH: length_reg <= cfg_data[16:0];
                    REG_STEP:   step_reg   <= cfg_data;
                    REG_GAIN:   gain_reg   <= cfg_data[8:0];
                    default:    ;
                endcase
            end
        end
    end

    smv_out_scale #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_out_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scale_ctrl),
        .sum    (sum_reg),
        .gain   (gain_reg),
        .voices (count_reg),
        .done   (done),
        .result (result)
    );

`ifndef SYNTHESIS
    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_OUT))
        else $error("result strobe without a finished frame");

    a_frame_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.opcode == OP_FRAME)) |=> busy)
        else $error("frame request did not start the voice walk");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(VOICE_COUNT))
        else $error("voice count above voice slots");

    a_acc_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> active_reg[voice_reg])
        else $error("mixing a voice that is not active");
`endif

endmodule

@@ sv/smv_out_scale.sv @@
// Output stage of the sample voice mixer: master gain, truncation toward zero,
// saturation and the result register with its strobe.
// Depends on smv_pkg.
module smv_out_scale #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  smv_pkg::scale_ctrl_t     ctrl,
    input  logic signed [SUM_W-1:0]  sum,
    input  logic [8:0]               gain,
    input  logic [CNT_W-1:0]         voices,
    output logic                     done,
    output smv_pkg::result_t         result
);
    import smv_pkg::*;

    localparam int PROD_W = SUM_W + 10;
    localparam int Q_W    = SUM_W + 2;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(SAT_MAX);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(SAT_MIN);

    logic [8:0]               gain_eff;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [Q_W-1:0]    quot;
    logic [15:0]              sat;
    logic                     done_reg;
    result_t                  result_reg;

    assign gain_eff  = (gain > GAIN_UNITY) ? GAIN_UNITY : gain;
    assign prod_next = sum * $signed({1'b0, gain_eff});

    always_comb
    begin
        quot = prod_reg[PROD_W-1:8]
             + Q_W'({1'b0, prod_reg[PROD_W-1] && (prod_reg[7:0] != 8'd0)});
        priority if (quot > Q_MAX)
        begin
            sat = Q_MAX[15:0];
        end
        else if (quot < Q_MIN)
        begin
            sat = Q_MIN[15:0];
        end
        else
        begin
            sat = quot[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.out_en)
        begin
            result_reg.mixed_sample  <= sat;
            result_reg.active_voices <= 4'(voices);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.out_en;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for sample_voice_mixer_core: directed and random requests, a mixing
// predictor of its own, and a checker that compares every result strobe with it.
// Depends on smv_pkg and sample_voice_mixer_core.
module testbench;
    import smv_pkg::*;

    localparam int VOICES = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    request_t          request = '0;
    logic              done;
    result_t           result;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = REG_LENGTH;
    logic [CFG_W-1:0]  cfg_data = '0;

    logic signed [15:0] pcm_mem [0:65535];
    logic [39:0]        voice_pos [VOICES];
    logic               voice_on [VOICES];
    logic [16:0]        cfg_length;
    logic [21:0]        cfg_step;
    logic [8:0]         cfg_gain;

    result_t pending_mixes [$];
    int      mismatches = 0;
    int      cycles = 0;

    sample_voice_mixer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic request_t make_request(logic [1:0] op, logic [15:0] addr,
                                              logic [15:0] value);
        request_t req;
        req.opcode       = op;
        req.address      = addr;
        req.sample_value = value;
        return req;
    endfunction

    function automatic int voices_playing();
        int count;
        count = 0;
        for (int v = 0; v < VOICES; v++)
            if (voice_on[v])
                count++;
        return count;
    endfunction

    // Stops ended voices, advances the rest a frame, returns the expected mix.
    function automatic result_t mix_frame();
        result_t     res;
        longint      acc;
        longint      scaled;
        longint      gain_eff;
        longint      p0;
        longint      p1;
        longint      frac;
        logic [15:0] idx;
        logic [15:0] idx_next;
        int          count;
        acc = 0;
        count = 0;
        for (int v = 0; v < VOICES; v++)
        begin
            if (!voice_on[v])
                continue;
            if (longint'(voice_pos[v]) + 65536 >= (longint'(cfg_length) << 16))
            begin
                voice_on[v] = 1'b0;
                continue;
            end
            idx = voice_pos[v][31:16];
            idx_next = idx + 16'd1;
            p0 = pcm_mem[idx];
            p1 = pcm_mem[idx_next];
            frac = voice_pos[v][15:0];
            acc += (p0 * 65536 + (p1 - p0) * frac) / 65536;
            voice_pos[v] = voice_pos[v] + cfg_step;
            count++;
        end
        gain_eff = (cfg_gain > GAIN_UNITY) ? GAIN_UNITY : cfg_gain;
        scaled = (acc * gain_eff) / 256;
        if (scaled > SAT_MAX)
            scaled = SAT_MAX;
        else if (scaled < SAT_MIN)
            scaled = SAT_MIN;
        res.mixed_sample = scaled[15:0];
        res.active_voices = count[3:0];
        return res;
    endfunction

    function automatic void apply_request(request_t req);
        int slot;
        case (req.opcode)
            OP_WRITE:
                pcm_mem[req.address] = req.sample_value;
            OP_TRIGGER:
                if (cfg_length != 0)
                begin
                    slot = 0;
                    for (int v = VOICES - 1; v >= 0; v--)
                        if (!voice_on[v])
                            slot = v;
                    voice_pos[slot] = '0;
                    voice_on[slot] = 1'b1;
                end
            OP_FRAME:
                pending_mixes.push_back(mix_frame());
            default:
                ;
        endcase
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (done === 1'b1)
        begin
            if (pending_mixes.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected result: expected none actual %0d / %0d", $time,
                         result.mixed_sample, result.active_voices);
            end
            else
            begin
                want = pending_mixes.pop_front();
                if (result.mixed_sample !== want.mixed_sample)
                begin
                    mismatches++;
                    $display("%0t mixed_sample mismatch: expected %0d actual %0d", $time,
                             want.mixed_sample, result.mixed_sample);
                end
                if (result.active_voices !== want.active_voices)
                begin
                    mismatches++;
                    $display("%0t active_voices mismatch: expected %0d actual %0d", $time,
                             want.active_voices, result.active_voices);
                end
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with start still high.
    task automatic send_request(request_t req);
        start <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        apply_request(req);
        @(negedge clk);
    endtask

    task automatic pause_sender(int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain_frames();
        start <= 1'b0;
        while (pending_mixes.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_settings(logic [16:0] len, logic [21:0] step, logic [8:0] gain);
        drain_frames();
        cfg_we <= 1'b1;
        cfg_index <= REG_LENGTH;
        cfg_data <= CFG_W'(len);
        @(negedge clk);
        cfg_index <= REG_STEP;
        cfg_data <= step;
        @(negedge clk);
        cfg_index <= REG_GAIN;
        cfg_data <= CFG_W'(gain);
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_length = len;
        cfg_step = step;
        cfg_gain = gain;
    endtask

    task automatic send_frames(int n);
        repeat (n) send_request(make_request(OP_FRAME, 16'($urandom), 16'($urandom)));
    endtask

    // With the reset length of zero a trigger is ignored and a frame mixes nothing.
    task automatic test_reset_state();
        send_frames(1);
        send_request(make_request(OP_TRIGGER, 16'hFFFF, 16'hFFFF));
        send_request(make_request(OP_UNUSED, 16'h1234, 16'h8000));
        send_frames(1);
    endtask

    // Every word that a voice can reach is written before any voice can read it.
    task automatic test_fill_memory();
        for (int a = 0; a < 256; a++)
            send_request(make_request(OP_WRITE, 16'(a), 16'($urandom)));
    endtask

    task automatic test_directed_mix();
        load_settings(17'd4, 22'd32768, 9'd256);
        send_request(make_request(OP_WRITE, 16'd0, 16'h7FFF));
        send_request(make_request(OP_WRITE, 16'd1, 16'h8000));
        send_request(make_request(OP_WRITE, 16'd2, 16'h7FFF));
        send_request(make_request(OP_WRITE, 16'd3, 16'h8000));
        repeat (VOICES + 1) send_request(make_request(OP_TRIGGER, 16'd0, 16'd0));
        send_frames(8);
        send_request(make_request(OP_UNUSED, 16'hFFFF, 16'h7FFF));
        load_settings(17'd1, 22'd65536, 9'd511);
        send_request(make_request(OP_TRIGGER, 16'd0, 16'd0));
        send_frames(1);
        load_settings(17'd0, 22'd65536, 9'd256);
        send_request(make_request(OP_TRIGGER, 16'd0, 16'd0));
        send_frames(1);
        load_settings(17'd6, 22'd0, 9'd511);
        repeat (3) send_request(make_request(OP_TRIGGER, 16'd0, 16'd0));
        send_frames(3);
        load_settings(17'd6, 22'd65536, 9'd128);
        send_frames(2);
        load_settings(17'd2, 22'd65536, 9'd0);
        send_frames(1);
    endtask

    // A voice at the largest step runs to its end; the longest lengths are played
    // only while every voice stays near the start of memory.
    task automatic test_long_playback();
        load_settings(17'd256, 22'd4194303, 9'd256);
        send_request(make_request(OP_TRIGGER, 16'd0, 16'd0));
        while (voices_playing() != 0)
            send_frames(1);
        load_settings(17'h1FFFF, 22'd0, 9'd256);
        repeat (2) send_request(make_request(OP_TRIGGER, 16'd0, 16'd0));
        send_frames(3);
        load_settings(17'd65536, 22'd65536, 9'd256);
        send_frames(20);
    endtask

    task automatic test_random_mix();
        int          idle_pct;
        int          roll;
        logic [1:0]  op;
        logic [15:0] addr;
        logic [16:0] len;
        logic [21:0] step;
        logic [8:0]  gain;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                1: idle_pct = 59;
                3: idle_pct = 29;
                default: idle_pct = 0;
            endcase
            case ($urandom_range(0, 9))
                0: len = 17'd1;
                1: len = 17'd256;
                2: len = 17'd255;
                3: len = 17'd0;
                4: len = 17'($urandom_range(2, 256));
                default: len = 17'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 7))
                0: step = 22'd0;
                1: step = 22'h3FFFFF;
                2: step = 22'd65536;
                3: step = 22'($urandom_range(1, 4194303));
                default: step = 22'($urandom_range(1, 262144));
            endcase
            case ($urandom_range(0, 5))
                0: gain = 9'd0;
                1: gain = 9'd511;
                2: gain = GAIN_UNITY;
                default: gain = 9'($urandom_range(0, 511));
            endcase
            load_settings(len, step, gain);
            for (int n = 0; n < 150; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    op = OP_WRITE;
                else if (roll < 35)
                    op = OP_TRIGGER;
                else if (roll < 95)
                    op = OP_FRAME;
                else
                    op = OP_UNUSED;
                if ($urandom_range(0, 3) == 0)
                    addr = 16'($urandom);
                else
                    addr = 16'($urandom_range(0, 63));
                send_request(make_request(op, addr, 16'($urandom)));
                if ($urandom_range(0, 99) < idle_pct)
                begin
                    if ($urandom_range(0, 9) == 0)
                        pause_sender($urandom_range(7, 60));
                    else
                        pause_sender($urandom_range(1, 6));
                end
                else if ($urandom_range(0, 63) == 0)
                    drain_frames();
            end
        end
    endtask

    initial
    begin
        for (int v = 0; v < VOICES; v++)
        begin
            voice_pos[v] = '0;
            voice_on[v] = 1'b0;
        end
        cfg_length = LENGTH_RESET;
        cfg_step = STEP_RESET;
        cfg_gain = GAIN_RESET;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_state();
        test_fill_memory();
        test_directed_mix();
        test_long_playback();
        test_random_mix();
        drain_frames();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
sv/smv_pkg.sv
sv/smv_out_scale.sv
sv/sample_voice_mixer_core.sv
test/testbench.sv
